// ===== rtl/ksc_pkg.sv =====
// Package for the k-mer spectrum counter: codes, record types, state encoding
// and the shared k and reverse-complement helpers.
// No dependencies; every other file of the block but ksc_queue imports it.
`default_nettype none

package ksc_pkg;

	localparam int K_MAX_DEF      = 8;
	localparam int COUNT_BITS_DEF = 24;
	localparam int KMAX_LIM       = 12;
	localparam int CODE_MAX_W     = 2 * KMAX_LIM;
	localparam int KLEN_W         = 4;
	localparam int CMD_W          = 2;
	localparam int KIND_W         = 2;
	localparam int BASE_W         = 8;
	localparam int ROW_W          = 16;
	localparam int COL_W          = 16;
	localparam int COUNT_W        = 24;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_KMER_LEN = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CANON    = 1'd1;

	localparam logic [BASE_W-1:0] CH_A = 8'h41;
	localparam logic [BASE_W-1:0] CH_C = 8'h43;
	localparam logic [BASE_W-1:0] CH_G = 8'h47;
	localparam logic [BASE_W-1:0] CH_T = 8'h54;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_END   = 2'd1,
		CMD_FETCH = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS = 2'd0,
		KIND_ENTRY  = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_INC   = 2'd0,
		OP_END   = 2'd1,
		OP_FETCH = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t         op;
		logic             bad;
		logic [ROW_W-1:0] row;
	} op_t;

	typedef struct packed {
		kind_t              kind;
		logic               status;
		logic [ROW_W-1:0]   row_out;
		logic [COL_W-1:0]   column;
		logic [COUNT_W-1:0] count;
	} res_t;

	typedef struct packed {
		logic clearing;
		logic walking;
		logic flush_pending;
	} bk_stat_t;

	typedef enum logic [2:0] {
		S_CLEAR    = 3'd0,
		S_IDLE     = 3'd1,
		S_INC      = 3'd2,
		S_WALK_RD  = 3'd3,
		S_WALK_CHK = 3'd4
	} bk_state_t;

	// A k of zero behaves as one; anything above the build limit as the limit.
	function automatic logic [KLEN_W-1:0] eff_k(input logic [KLEN_W-1:0] raw,
		input logic [KLEN_W-1:0] kmax);
		logic [KLEN_W-1:0] r;
		r = raw;
		if (raw == '0) r = KLEN_W'(1);
		else if (raw > kmax) r = kmax;
		return r;
	endfunction

	// Digit j of the result is the complement of digit k-1-j of the code.
	function automatic logic [CODE_MAX_W-1:0] rev_comp(input logic [CODE_MAX_W-1:0] code,
		input logic [KLEN_W-1:0] k);
		logic [CODE_MAX_W-1:0] r;
		logic [CODE_MAX_W-1:0] sh;
		logic [KLEN_W-1:0]     src;
		r = '0;
		for (int j = 0; j < KMAX_LIM; j++) begin
			src = k - KLEN_W'(j) - KLEN_W'(1);
			sh = code >> {src, 1'b0};
			if (KLEN_W'(j) < k) r[2*j +: 2] = ~sh[1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ksc_if.sv =====
// Handshake channels of the k-mer spectrum counter: input items, result
// items and configuration writes. Depends on ksc_pkg.
`default_nettype none

interface ksc_in_if;
	import ksc_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [BASE_W-1:0]   base;
	logic [ROW_W-1:0]    row;
	modport source (output valid, command, base, row, input ready);
	modport sink (input valid, command, base, row, output ready);
endinterface

interface ksc_out_if;
	import ksc_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic                status;
	logic [ROW_W-1:0]    row_out;
	logic [COL_W-1:0]    column;
	logic [COUNT_W-1:0]  count;
	modport source (output valid, kind, status, row_out, column, count, input ready);
	modport sink (input valid, kind, status, row_out, column, count, output ready);
endinterface

interface ksc_cfg_if;
	import ksc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/kmer_spectrum_counter_unit.sv =====
// Top level of the k-mer spectrum counter: configuration registers, front end,
// operation queue and count-memory back end. Depends on ksc_pkg, ksc_if,
// ksc_front, ksc_queue and ksc_back.
`default_nettype none

// The front end takes one word per cycle, while the queue has room and no
// clearing pass runs, into a four-entry operation queue; the back end owns the
// single count memory of 4^K_MAX entries (one write port, one registered read
// port) and sets the sustained rate. A base that completes a k-mer costs a
// read and a write of its counter in the back end; other bases and unknown
// commands cost nothing there. After a sequence with a non-ACGT character an
// end command starts a clearing pass over all 4^K_MAX entries (65536 at the
// default K_MAX). A fetch walks the table, reading entries up to the nonzero
// entry it returns or the last entry of the table; a fetch with no drain open
// or with the walk already at the end answers with a drain-done word. After
// reset the same clearing pass runs and no input word is accepted until it
// ends; configuration writes are taken at any time. A result waits in an
// output register while the next words go in.
module kmer_spectrum_counter_unit #(
	parameter int K_MAX      = ksc_pkg::K_MAX_DEF,
	parameter int COUNT_BITS = ksc_pkg::COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ksc_in_if.sink    item,
	ksc_out_if.source result,
	ksc_cfg_if.sink   cfg
);
	import ksc_pkg::*;

	localparam int AW = 2 * K_MAX;
	localparam int QW = $bits(op_t) + AW;

	logic [KLEN_W-1:0] kmer_len_q;
	logic              canonical_q;
	logic [KLEN_W-1:0] k;

	logic              f_push;
	op_t               f_op;
	logic [AW-1:0]     f_addr;
	logic              q_ready;
	logic              q_valid;
	logic [QW-1:0]     q_rdata;
	logic              q_pop;
	op_t               q_op;
	logic [AW-1:0]     q_addr;
	bk_stat_t          bk_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q  <= KLEN_W'(1);
			canonical_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_KMER_LEN: kmer_len_q <= cfg.data[KLEN_W-1:0];
				REG_CANON: canonical_q <= cfg.data[0];
				default: canonical_q <= canonical_q;
			endcase
		end
	end

	assign k = eff_k(kmer_len_q, KLEN_W'(K_MAX));

	ksc_front #(
		.K_MAX (K_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.k         (k),
		.canonical (canonical_q),
		.clearing  (bk_stat.clearing),
		.q_ready   (q_ready),
		.q_push    (f_push),
		.q_op      (f_op),
		.q_addr    (f_addr)
	);

	ksc_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_op, f_addr}),
		.ready  (q_ready),
		.valid  (q_valid),
		.rdata  (q_rdata),
		.pop    (q_pop)
	);

	assign q_op   = op_t'(q_rdata[QW-1:AW]);
	assign q_addr = q_rdata[AW-1:0];

	ksc_back #(
		.K_MAX      (K_MAX),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_addr    (q_addr),
		.q_pop     (q_pop),
		.k         (k),
		.canonical (canonical_q),
		.result    (result),
		.stat      (bk_stat)
	);

	// A drain walk only runs while a drain is pending.
	a_walk_needs_flush: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.walking |-> bk_stat.flush_pending)
		else $error("drain walk running with no drain pending");

	// No word may slip into the queue while the count memory is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |-> !bk_stat.clearing)
		else $error("input word accepted during clearing pass");

	// Status and drain-done words carry no column and no count.
	a_plain_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.kind != KIND_ENTRY)) |->
		((result.column == '0) && (result.count == '0)))
		else $error("status or drain-done word with column or count set");

	// Leaving the clearing pass needs a full sweep, so it never ends straight after starting.
	a_clear_spans: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bk_stat.clearing) |=> bk_stat.clearing || (K_MAX == 0))
		else $error("clearing pass ended after one cycle");

endmodule

`default_nettype wire

// ===== rtl/ksc_front.sv =====
// Front end of the k-mer spectrum counter: accepts words, keeps the rolling
// window and the bad-base flag, and queues counter, end and fetch operations.
// Depends on ksc_pkg and ksc_if.
`default_nettype none

module ksc_front #(
	parameter int K_MAX = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ksc_in_if.sink                      item,
	input  logic [ksc_pkg::KLEN_W-1:0]  k,
	input  logic                        canonical,
	input  logic                        clearing,
	input  logic                        q_ready,
	output logic                        q_push,
	output ksc_pkg::op_t                q_op,
	output logic [2*K_MAX-1:0]          q_addr
);
	import ksc_pkg::*;

	localparam int AW = 2 * K_MAX;

	logic [AW-1:0]     window_q;
	logic [KLEN_W-1:0] seen_q;
	logic              bad_q;

	logic              accept;
	logic              base_ok;
	logic [1:0]        digit;
	logic [AW:0]       limit;
	logic [AW-1:0]     mask;
	logic [AW-1:0]     win_next;
	logic [AW-1:0]     rc;
	logic [KLEN_W-1:0] seen_next;

	assign item.ready = q_ready && !clearing;
	assign accept     = item.valid && item.ready;

	always_comb begin
		base_ok = 1'b1;
		digit   = 2'd0;
		unique case (item.base)
			CH_A: digit = 2'd0;
			CH_C: digit = 2'd1;
			CH_G: digit = 2'd2;
			CH_T: digit = 2'd3;
			default: base_ok = 1'b0;
		endcase
	end

	assign limit     = (AW+1)'(1) << {k, 1'b0};
	assign mask      = AW'(limit - 1'b1);
	assign win_next  = AW'({window_q, digit}) & mask;
	assign seen_next = (seen_q == '1) ? seen_q : seen_q + 1'b1;
	assign rc        = AW'(rev_comp(CODE_MAX_W'(win_next), k));
	assign q_addr    = (canonical && (rc < win_next)) ? rc : win_next;

	always_comb begin
		q_push    = 1'b0;
		q_op.op   = OP_INC;
		q_op.bad  = bad_q;
		q_op.row  = item.row;
		if (accept) begin
			unique case (item.command)
				CMD_PUSH: begin
					q_push  = base_ok && (seen_next >= k);
					q_op.op = OP_INC;
				end
				CMD_END: begin
					q_push  = 1'b1;
					q_op.op = OP_END;
				end
				CMD_FETCH: begin
					q_push  = 1'b1;
					q_op.op = OP_FETCH;
				end
				default: q_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			bad_q    <= 1'b0;
		end else if (accept) begin
			unique case (item.command)
				CMD_PUSH: begin
					if (base_ok) begin
						window_q <= win_next;
						seen_q   <= seen_next;
					end else begin
						bad_q <= 1'b1;
					end
				end
				CMD_END: begin
					window_q <= '0;
					seen_q   <= '0;
					bad_q    <= 1'b0;
				end
				default: bad_q <= bad_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ksc_queue.sv =====
// Short first-in first-out queue that decouples the front end from the
// counter-memory back end. Depends on nothing but its parameters.
`default_nettype none

module ksc_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         ready,
	output logic         valid,
	output logic [W-1:0] rdata,
	input  logic         pop
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign ready   = fill_q != CW'(DEPTH);
	assign valid   = fill_q != '0;
	assign rdata   = slot_q[rd_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ksc_back.sv =====
// Back end of the k-mer spectrum counter: the count memory, its clearing
// sweep, counter updates, the drain walk and the result register.
// Depends on ksc_pkg and ksc_if.
`default_nettype none

module ksc_back #(
	parameter int K_MAX      = 8,
	parameter int COUNT_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  ksc_pkg::op_t                q_op,
	input  logic [2*K_MAX-1:0]          q_addr,
	output logic                        q_pop,
	input  logic [ksc_pkg::KLEN_W-1:0]  k,
	input  logic                        canonical,
	ksc_out_if.source                   result,
	output ksc_pkg::bk_stat_t           stat
);
	import ksc_pkg::*;

	localparam int AW    = 2 * K_MAX;
	localparam int DEPTH = 1 << AW;

	logic [COUNT_BITS-1:0] mem [DEPTH];

	bk_state_t             state_q;
	bk_state_t             state_d;
	logic [AW:0]           walk_q;
	logic [AW-1:0]         compact_q;
	logic [AW-1:0]         clr_q;
	logic [AW-1:0]         inc_addr_q;
	logic                  flush_q;
	logic [ROW_W-1:0]      row_q;
	logic [COUNT_BITS-1:0] rd_q;
	res_t                  res_q;
	logic                  res_valid_q;

	logic [AW:0]           limit;
	logic [AW-1:0]         code;
	logic [AW-1:0]         rc;
	logic                  canon;
	logic                  hit;
	logic                  last;
	logic                  fetch_walk;
	logic                  slot_free;
	logic                  chk_go;

	logic                  mem_we;
	logic                  mem_re;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic [COUNT_BITS-1:0] wdata;
	logic                  emit;
	res_t                  emit_res;
	logic                  walk_rst;
	logic                  walk_step;
	logic                  compact_step;
	logic                  flush_set;
	logic                  flush_clr;
	logic                  row_load;
	logic                  clr_step;
	logic                  inc_load;

	assign limit      = (AW+1)'(1) << {k, 1'b0};
	assign code       = walk_q[AW-1:0];
	assign rc         = AW'(rev_comp(CODE_MAX_W'(code), k));
	assign canon      = !canonical || (code <= rc);
	assign hit        = canon && (rd_q != '0);
	assign last       = (walk_q + 1'b1) == limit;
	assign fetch_walk = flush_q && (walk_q < limit);
	assign slot_free  = !res_valid_q || result.ready;
	// A walk step that would produce a word waits for the result register.
	assign chk_go     = slot_free || !(hit || last);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_op.op)
						OP_INC: state_d = S_INC;
						OP_END: if (slot_free && q_op.bad) state_d = S_CLEAR;
						OP_FETCH: if (fetch_walk) state_d = S_WALK_RD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INC: state_d = S_IDLE;
			S_WALK_RD: state_d = S_WALK_CHK;
			S_WALK_CHK: if (chk_go) state_d = (hit || last) ? S_IDLE : S_WALK_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop            = 1'b0;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		waddr            = clr_q;
		raddr            = code;
		wdata            = '0;
		emit             = 1'b0;
		emit_res.kind    = KIND_STATUS;
		emit_res.status  = 1'b0;
		emit_res.row_out = row_q;
		emit_res.column  = '0;
		emit_res.count   = '0;
		walk_rst         = 1'b0;
		walk_step        = 1'b0;
		compact_step     = 1'b0;
		flush_set        = 1'b0;
		flush_clr        = 1'b0;
		row_load         = 1'b0;
		clr_step         = 1'b0;
		inc_load         = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				clr_step = 1'b1;
			end
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_op.op)
						OP_INC: begin
							q_pop    = 1'b1;
							mem_re   = 1'b1;
							raddr    = q_addr;
							inc_load = 1'b1;
						end
						OP_END: begin
							if (slot_free) begin
								q_pop            = 1'b1;
								emit             = 1'b1;
								emit_res.status  = q_op.bad;
								emit_res.row_out = q_op.row;
								walk_rst         = 1'b1;
								if (q_op.bad) begin
									flush_clr = 1'b1;
								end else begin
									flush_set = 1'b1;
									row_load  = 1'b1;
								end
							end
						end
						OP_FETCH: begin
							if (fetch_walk) begin
								q_pop = 1'b1;
							end else if (slot_free) begin
								q_pop         = 1'b1;
								emit          = 1'b1;
								emit_res.kind = KIND_DONE;
								flush_clr     = 1'b1;
							end
						end
						default: q_pop = 1'b0;
					endcase
				end
			end
			S_INC: begin
				mem_we = 1'b1;
				waddr  = inc_addr_q;
				wdata  = (rd_q == '1) ? rd_q : rd_q + 1'b1;
			end
			S_WALK_RD: mem_re = 1'b1;
			S_WALK_CHK: begin
				if (chk_go) begin
					// Every entry passed by the walk is left at zero.
					mem_we       = 1'b1;
					waddr        = code;
					walk_step    = 1'b1;
					compact_step = canon;
					if (hit) begin
						emit            = 1'b1;
						emit_res.kind   = KIND_ENTRY;
						emit_res.column = COL_W'(canonical ? compact_q : code);
						emit_res.count  = COUNT_W'(rd_q);
					end else if (last) begin
						emit          = 1'b1;
						emit_res.kind = KIND_DONE;
						flush_clr     = 1'b1;
					end
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (emit) res_q <= emit_res;
		if (inc_load) inc_addr_q <= q_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			walk_q      <= '0;
			compact_q   <= '0;
			flush_q     <= 1'b0;
			row_q       <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (walk_rst) begin
				walk_q    <= '0;
				compact_q <= '0;
			end else if (walk_step) begin
				walk_q <= walk_q + 1'b1;
				if (compact_step) compact_q <= compact_q + 1'b1;
			end
			if (flush_set) flush_q <= 1'b1;
			else if (flush_clr) flush_q <= 1'b0;
			if (row_load) row_q <= q_op.row;
			// The sweep counter wraps to zero as a pass ends, ready for the next.
			if (clr_step) clr_q <= clr_q + 1'b1;
			if (emit) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.kind    = res_q.kind;
	assign result.status  = res_q.status;
	assign result.row_out = res_q.row_out;
	assign result.column  = res_q.column;
	assign result.count   = res_q.count;

	assign stat.clearing      = state_q == S_CLEAR;
	assign stat.walking       = (state_q == S_WALK_RD) || (state_q == S_WALK_CHK);
	assign stat.flush_pending = flush_q;

endmodule

`default_nettype wire
